### design/rfe_pkg.sv
`timescale 1ns / 1ps
package rfe_pkg;
	localparam int MAX_TERMS = 16;
	localparam int FRAC_BITS = 16;
	localparam int IDX_W = $clog2(MAX_TERMS);
	localparam int CNT_W = $clog2(MAX_TERMS + 1);

	typedef enum logic [1:0] {
		REQ_WR_NUM = 2'd0,
		REQ_WR_DEN = 2'd1,
		REQ_EVAL   = 2'd2,
		REQ_DERIV  = 2'd3
	} req_t;

	localparam logic CFG_NUM_TERMS = 1'b0;
	localparam logic CFG_DEN_TERMS = 1'b1;

	localparam logic signed [31:0] ONE_FX = 32'sd1 <<< FRAC_BITS;
	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NUM_INIT,
		ST_NUM_STEP,
		ST_DEN_INIT,
		ST_DEN_STEP,
		ST_DER_A,
		ST_DER_B,
		ST_DER_C,
		ST_DIV_INIT,
		ST_DIV_RUN,
		ST_DIV_DONE,
		ST_DONE
	} state_t;

	// datapath operations requested by the controller
	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLEAR,
		OP_LOAD_ONE,
		OP_HORNER_INIT,
		OP_HORNER_STEP,
		OP_SAVE_NUM,
		OP_SAVE_DEN,
		OP_DER_A,
		OP_DER_B,
		OP_DER_C,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_DIV_DONE,
		OP_PASS
	} op_t;

	typedef struct packed {
		op_t              op;
		logic             use_den;
		logic [IDX_W-1:0] idx;
		logic             deriv;
	} cmd_t;

	typedef struct packed {
		logic div_last;
	} sts_t;

	function automatic logic signed [31:0] sat64(input logic signed [63:0] v, output logic c);
		begin
			c = 1'b0;
			if (v > 64'sh0000_0000_7FFF_FFFF) begin
				c = 1'b1;
				sat64 = S32_MAX;
			end else if (v < -64'sh0000_0000_8000_0000) begin
				c = 1'b1;
				sat64 = S32_MIN;
			end else begin
				sat64 = v[31:0];
			end
		end
	endfunction
endpackage

### design/rfe_ctrl.sv
`timescale 1ns / 1ps
module rfe_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     go,
	input  logic                     deriv,
	input  logic [rfe_pkg::CNT_W-1:0] na,
	input  logic [rfe_pkg::CNT_W-1:0] nb,
	input  rfe_pkg::sts_t            sts,
	output rfe_pkg::cmd_t            cmd,
	output logic                     busy,
	output logic                     done
);
	import rfe_pkg::*;

	state_t state_q, state_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic deriv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			deriv_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
			if (go) deriv_q <= deriv;
		end
	end

	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		unique case (state_q)
			ST_IDLE: if (go) begin
				state_d = ST_NUM_INIT;
			end
			ST_NUM_INIT: begin
				idx_d = IDX_W'(1);
				if (na <= CNT_W'(1)) state_d = ST_DEN_INIT;
				else state_d = ST_NUM_STEP;
			end
			ST_NUM_STEP: begin
				idx_d = idx_q + 1'b1;
				if (CNT_W'(idx_q) + 1'b1 >= na) state_d = ST_DEN_INIT;
			end
			ST_DEN_INIT: begin
				idx_d = IDX_W'(1);
				if (nb == '0) state_d = ST_DONE;
				else if (nb == CNT_W'(1)) state_d = deriv_q ? ST_DER_A : ST_DIV_INIT;
				else state_d = ST_DEN_STEP;
			end
			ST_DEN_STEP: begin
				idx_d = idx_q + 1'b1;
				if (CNT_W'(idx_q) + 1'b1 >= nb) state_d = deriv_q ? ST_DER_A : ST_DIV_INIT;
			end
			ST_DER_A: state_d = ST_DER_B;
			ST_DER_B: state_d = ST_DER_C;
			ST_DER_C: state_d = ST_DIV_INIT;
			ST_DIV_INIT: state_d = ST_DIV_RUN;
			ST_DIV_RUN: if (sts.div_last) state_d = ST_DIV_DONE;
			ST_DIV_DONE: state_d = ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '{op: OP_NONE, use_den: 1'b0, idx: idx_q, deriv: deriv_q};
		busy = (state_q != ST_IDLE);
		done = 1'b0;
		unique case (state_q)
			ST_IDLE: cmd.op = go ? OP_CLEAR : OP_NONE;
			ST_NUM_INIT: begin
				cmd.op = (na == '0) ? OP_LOAD_ONE : OP_HORNER_INIT;
				cmd.idx = '0;
			end
			ST_NUM_STEP: cmd.op = OP_HORNER_STEP;
			ST_DEN_INIT: begin
				cmd.op = (nb == '0) ? OP_PASS : OP_SAVE_NUM;
				cmd.use_den = 1'b1;
				cmd.idx = '0;
			end
			ST_DEN_STEP: begin
				cmd.op = OP_HORNER_STEP;
				cmd.use_den = 1'b1;
			end
			ST_DER_A: cmd.op = OP_DER_A;
			ST_DER_B: cmd.op = OP_DER_B;
			ST_DER_C: cmd.op = OP_DER_C;
			ST_DIV_INIT: cmd.op = OP_DIV_INIT;
			ST_DIV_RUN: cmd.op = OP_DIV_STEP;
			ST_DIV_DONE: cmd.op = OP_DIV_DONE;
			ST_DONE: done = 1'b1;
			default: cmd.op = OP_NONE;
		endcase
	end
endmodule

### design/rfe_datapath.sv
`timescale 1ns / 1ps
module rfe_datapath (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic                     wr_den,
	input  logic [rfe_pkg::IDX_W-1:0] wr_idx,
	input  logic signed [31:0]       wr_data,
	input  logic                     x_load,
	input  rfe_pkg::cmd_t            cmd,
	output rfe_pkg::sts_t            sts,
	output logic signed [31:0]       res,
	output logic                     dz,
	output logic                     sat
);
	import rfe_pkg::*;

	logic signed [31:0] num_mem [MAX_TERMS];
	logic signed [31:0] den_mem [MAX_TERMS];
	logic signed [31:0] x_q, acc_q, dacc_q, p_q, pp_q, t_q;
	logic clip_q, dz_q;
	logic [63:0] rem_q;
	logic [63:0] dvs_q;
	logic [63:0] quo_q;
	logic [6:0] dcnt_q;
	logic nneg_q, dneg_q;

	// coefficient read (async read of 16-entry register file at one index)
	logic signed [31:0] coef;
	assign coef = cmd.use_den ? den_mem[cmd.idx] : num_mem[cmd.idx];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			if (wr_den) den_mem[wr_idx] <= wr_data;
			else num_mem[wr_idx] <= wr_data;
		end
	end

	// shared multiplier with truncation and saturation
	logic signed [31:0] ma, mb, mr;
	logic mc;
	logic signed [63:0] prod;
	always_comb begin
		ma = x_q;
		mb = acc_q;
		unique case (cmd.op)
			OP_DER_A: begin ma = pp_q; mb = acc_q; end
			OP_DER_B: begin ma = p_q; mb = dacc_q; end
			OP_DER_C: begin ma = acc_q; mb = acc_q; end
			default: begin ma = x_q; mb = acc_q; end
		endcase
		prod = 64'(ma) * 64'(mb);
		mr = sat64(prod >>> FRAC_BITS, mc);
	end

	// derivative-side product for Horner step: x*dacc
	logic signed [31:0] mdr;
	logic mdc;
	logic signed [63:0] dprod;
	assign dprod = 64'(x_q) * 64'(dacc_q);
	always_comb mdr = sat64(dprod >>> FRAC_BITS, mdc);

	logic signed [31:0] s1, s2;
	logic c1, c2;
	always_comb begin
		s1 = sat64(64'(acc_q) + 64'(mdr), c1);
		s2 = sat64(64'(coef) + 64'(mr), c2);
	end

	logic signed [31:0] sub_r;
	logic csub;
	always_comb sub_r = sat64(64'(t_q) - 64'(mr), csub);

	logic [63:0] trial;
	assign trial = {rem_q[62:0], quo_q[63]} - dvs_q;

	logic signed [63:0] qs;
	logic signed [31:0] qsat;
	logic cq;
	always_comb begin
		qs = (nneg_q ^ dneg_q) ? -$signed(quo_q) : $signed(quo_q);
		qsat = sat64(qs, cq);
	end

	assign sts.div_last = (dcnt_q == 7'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_q <= 1'b0;
			dz_q <= 1'b0;
			dcnt_q <= '0;
		end else begin
			unique case (cmd.op)
				OP_CLEAR: begin clip_q <= 1'b0; dz_q <= 1'b0; end
				OP_HORNER_STEP: clip_q <= clip_q | mc | c2 | mdc | c1;
				OP_DER_A, OP_DER_B, OP_DER_C: clip_q <= clip_q | mc | (cmd.op == OP_DER_B && csub);
				OP_DIV_INIT: dcnt_q <= 7'd64;
				OP_DIV_STEP: dcnt_q <= dcnt_q - 1'b1;
				OP_DIV_DONE: clip_q <= clip_q | (!dz_q & cq);
				default: ;
			endcase
			if (cmd.op == OP_DIV_INIT && acc_q == '0) dz_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (x_load) x_q <= wr_data;
		unique case (cmd.op)
			OP_LOAD_ONE: begin acc_q <= ONE_FX; dacc_q <= '0; end
			OP_HORNER_INIT: begin acc_q <= coef; dacc_q <= '0; end
			OP_HORNER_STEP: begin dacc_q <= s1; acc_q <= s2; end
			OP_SAVE_NUM: begin
				p_q <= acc_q; pp_q <= dacc_q;
				acc_q <= coef; dacc_q <= '0;
				t_q <= cmd.deriv ? dacc_q : acc_q;
				res <= cmd.deriv ? dacc_q : acc_q;
			end
			OP_PASS: res <= cmd.deriv ? dacc_q : acc_q;
			OP_DER_A: t_q <= mr;
			OP_DER_B: begin p_q <= sub_r; end
			OP_DER_C: acc_q <= mr;
			OP_DIV_INIT: begin
				// divisor in acc_q (q or q*q); dividend p or p'q-pq'
				if (cmd.deriv) begin
					nneg_q <= p_q[31];
					quo_q <= {16'd0, (p_q[31] ? -48'(p_q) : 48'(p_q))} << FRAC_BITS;
				end else begin
					nneg_q <= p_q[31];
					quo_q <= {16'd0, (p_q[31] ? -48'(p_q) : 48'(p_q))} << FRAC_BITS;
				end
				dneg_q <= acc_q[31];
				dvs_q <= acc_q[31] ? -64'(acc_q) : 64'(acc_q);
				rem_q <= '0;
				t_q <= acc_q;
			end
			OP_DIV_STEP: begin
				if (!trial[63]) begin
					rem_q <= trial;
					quo_q <= {quo_q[62:0], 1'b1};
				end else begin
					rem_q <= {rem_q[62:0], quo_q[63]};
					quo_q <= {quo_q[62:0], 1'b0};
				end
			end
			OP_DIV_DONE: res <= dz_q ? S32_MAX : qsat;
			default: ;
		endcase
	end

	assign dz = dz_q;
	assign sat = clip_q & !dz_q | (clip_q & dz_q);
endmodule

### design/rational_function_evaluator_top.sv
`timescale 1ns / 1ps
// Rational function evaluator r(x) = p(x)/q(x), or its derivative, Q16.16.
// Command channel: an item (req_type, coeff_index, operand_value) is taken
// when start is high and busy is low. Write items (numerator or denominator
// coefficient) are stored at the accepting edge and give no result.
// Evaluation items run the numerator Horner loop (one coefficient per
// cycle on a shared multiplier pair), then, unless den_terms is zero,
// the denominator loop, for the derivative three quotient-rule steps,
// and a 64-step restoring divider, one bit a cycle. busy stays high
// through the done cycle, so the next item is taken in the cycle after it
// at the earliest.
// Result: result_value, divide_by_zero and saturated are valid with done,
// which is high for a single cycle; the receiver cannot stall and must
// take it then.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0 is
// num_terms, index 1 den_terms. cfg_ready is low while an item is in flight.
// Counts above 16 are clamped.
// Reset (arst_n low) clears both counts and the controller; coefficient
// tables are undefined until written.
module rational_function_evaluator_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         req_type,
	input  logic [3:0]         coeff_index,
	input  logic signed [31:0] operand_value,
	output logic               done,
	output logic signed [31:0] result_value,
	output logic               divide_by_zero,
	output logic               saturated,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [4:0]         cfg_data
);
	import rfe_pkg::*;

	logic [4:0] num_terms_q, den_terms_q;
	logic [CNT_W-1:0] na, nb;
	logic accept, is_eval, go;
	cmd_t cmd;
	sts_t sts;

	// hold off register writes while an evaluation is running
	assign cfg_ready = !busy;
	// hold the term counts; written only while idle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_terms_q <= '0;
			den_terms_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_NUM_TERMS) num_terms_q <= cfg_data;
			else den_terms_q <= cfg_data;
		end
	end

	// clamp counts to the table depth
	assign na = (num_terms_q > 5'(MAX_TERMS)) ? CNT_W'(MAX_TERMS) : CNT_W'(num_terms_q);
	assign nb = (den_terms_q > 5'(MAX_TERMS)) ? CNT_W'(MAX_TERMS) : CNT_W'(den_terms_q);

	assign accept = start && !busy;
	assign is_eval = req_type[1];
	assign go = accept && is_eval;

	rfe_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .go(go),
		.deriv(req_type == REQ_DERIV), .na(na), .nb(nb),
		.sts(sts), .cmd(cmd), .busy(busy), .done(done)
	);

	rfe_datapath u_dp (
		.clk(clk), .arst_n(arst_n),
		.wr_en(accept && !is_eval), .wr_den(req_type == REQ_WR_DEN),
		.wr_idx(coeff_index), .wr_data(operand_value), .x_load(go),
		.cmd(cmd), .sts(sts), .res(result_value),
		.dz(divide_by_zero), .sat(saturated)
	);

`ifndef SYNTHESIS
	// a result only leaves while an item is in flight
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
		else $error("done without busy");
	// a new evaluation always raises busy next cycle
	a_go_busy: assert property (@(posedge clk) disable iff (!arst_n) go |=> busy)
		else $error("busy not raised");
	// busy drops right after a result
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done |=> !busy)
		else $error("busy held after done");
`endif
endmodule

### tb/rational_function_evaluator_top_test.sv
`timescale 1ns / 1ps
module rational_function_evaluator_top_test;
	import rfe_pkg::*;

	localparam int CLK_HALF    = 6;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int RAND_ITEMS  = 1450;
	localparam int IDLE_PCT    = 15;
	localparam int SETTLE      = 120;

	typedef struct {
		logic signed [31:0] value;
		logic               dz;
		logic               sat;
	} fx_result_t;

	// directed plan: either a register setting or one item
	typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		logic [4:0]         n_cnt;
		logic [4:0]         d_cnt;
		req_t               req;
		logic [3:0]         idx;
		logic signed [31:0] operand;
		bit                 typed;
		fx_result_t         want;
	} row_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         req_type;
	logic [3:0]         coeff_index;
	logic signed [31:0] operand_value;
	logic               done;
	logic signed [31:0] result_value;
	logic               divide_by_zero;
	logic               saturated;
	logic               cfg_valid;
	logic               cfg_ready;
	logic               cfg_index;
	logic [4:0]         cfg_data;

	rational_function_evaluator_top u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.req_type       (req_type),
		.coeff_index    (coeff_index),
		.operand_value  (operand_value),
		.done           (done),
		.result_value   (result_value),
		.divide_by_zero (divide_by_zero),
		.saturated      (saturated),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	// Shadow copy of the coefficient tables and term counts.
	logic signed [31:0] num_coef [MAX_TERMS];
	logic signed [31:0] den_coef [MAX_TERMS];
	logic [4:0]         num_cnt;
	logic [4:0]         den_cnt;
	bit                 clipped;

	fx_result_t pending_results[$];
	row_t       plan[$];
	int         errors;
	int         cycles;
	bit         quiet;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Hard stop in case the block hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// ---------------- fixed-point arithmetic of the block ----------------

	// Clip to the signed 32-bit range and remember that clipping happened.
	function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			clipped = 1'b1;
			return 32'sh7FFF_FFFF;
		end
		if (v < -64'sd2147483648) begin
			clipped = 1'b1;
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] add_fx(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [63:0] aa, bb;
		aa = a;
		bb = b;
		return clip32(aa + bb);
	endfunction

	// Exact product, then an arithmetic shift drops the fraction (floor).
	function automatic logic signed [31:0] mul_fx(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [63:0] aa, bb;
		aa = a;
		bb = b;
		return clip32((aa * bb) >>> FRAC_BITS);
	endfunction

	// Scaled numerator over divisor, truncating toward zero.
	function automatic logic signed [31:0] div_fx(input logic signed [31:0] n,
			input logic signed [31:0] d);
		logic signed [63:0] nn, dd;
		nn = n;
		dd = d;
		nn = nn <<< FRAC_BITS;
		return clip32(nn / dd);
	endfunction

	function automatic int clamp_terms(input logic [4:0] t);
		return (t > MAX_TERMS) ? MAX_TERMS : int'(t);
	endfunction

	// Horner's rule over one table, giving value and first derivative.
	function automatic void horner_eval(input bit den_side, input int n,
			input logic signed [31:0] x, output logic signed [31:0] val,
			output logic signed [31:0] der);
		logic signed [31:0] c;
		val = den_side ? den_coef[0] : num_coef[0];
		der = 0;
		for (int i = 1; i < n; i++) begin
			c = den_side ? den_coef[i] : num_coef[i];
			der = add_fx(val, mul_fx(x, der));
			val = add_fx(c, mul_fx(x, val));
		end
	endfunction

	// Expected outcome of one evaluation item at point x.
	function automatic fx_result_t eval_rational(input req_t req,
			input logic signed [31:0] x);
		fx_result_t r;
		logic signed [31:0] p, pd, q, qd, top, bot;
		int na, nb;
		clipped = 1'b0;
		na = clamp_terms(num_cnt);
		nb = clamp_terms(den_cnt);
		r.dz = 1'b0;
		if (na == 0) begin
			p = ONE_FX;
			pd = 0;
		end else begin
			horner_eval(1'b0, na, x, p, pd);
		end
		if (nb == 0) begin
			r.value = (req == REQ_EVAL) ? p : pd;
		end else begin
			horner_eval(1'b1, nb, x, q, qd);
			if (req == REQ_EVAL) begin
				top = p;
				bot = q;
			end else begin
				// quotient rule: (p'q - pq') / q^2
				top = add_fx(mul_fx(pd, q), 0) ;
				top = clip32(64'(signed'(top)) - 64'(signed'(mul_fx(p, qd))));
				bot = mul_fx(q, q);
			end
			if (bot == 0) begin
				r.dz = 1'b1;
				r.value = S32_MAX;
			end else begin
				r.value = div_fx(top, bot);
			end
		end
		r.sat = clipped;
		return r;
	endfunction

	// ---------------- stimulus ----------------

	// Operand mix: half small values so results stay in range, some extremes,
	// some full-width noise.
	function automatic logic signed [31:0] pick_operand();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
			5: begin
				case ($urandom_range(0, 3))
					0: return S32_MAX;
					1: return S32_MIN;
					2: return 0;
					default: return ONE_FX;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	// Present one item; hold start until busy is low at an edge.
	task automatic send_item(input req_t req, input logic [3:0] idx,
			input logic signed [31:0] operand, input bit typed, input fx_result_t want);
		if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start         <= 1'b1;
		req_type      <= req;
		coeff_index   <= idx;
		operand_value <= operand;
		do @(posedge clk); while (busy);
		// accepted at this edge: update the shadow tables or queue a result
		case (req)
			REQ_WR_NUM: num_coef[idx] = operand;
			REQ_WR_DEN: den_coef[idx] = operand;
			default: pending_results.push_back(typed ? want : eval_rational(req, operand));
		endcase
	endtask

	// Let the block drain, then write both term counts.
	task automatic set_terms(input logic [4:0] n_cnt, input logic [4:0] d_cnt);
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_NUM_TERMS;
		cfg_data  <= n_cnt;
		do @(posedge clk); while (!cfg_ready);
		num_cnt = n_cnt;
		cfg_index <= CFG_DEN_TERMS;
		cfg_data  <= d_cnt;
		do @(posedge clk); while (!cfg_ready);
		den_cnt = d_cnt;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic void add_cfg(input logic [4:0] n_cnt, input logic [4:0] d_cnt);
		row_t r;
		r = '{kind: ROW_CFG, n_cnt: n_cnt, d_cnt: d_cnt, req: REQ_EVAL, idx: 0,
			operand: 0, typed: 0, want: '{0, 0, 0}};
		plan.push_back(r);
	endfunction

	function automatic void add_item(input req_t req, input logic [3:0] idx,
			input logic signed [31:0] operand, input bit typed,
			input logic signed [31:0] v, input logic dz, input logic sat);
		row_t r;
		r = '{kind: ROW_ITEM, n_cnt: 0, d_cnt: 0, req: req, idx: idx,
			operand: operand, typed: typed, want: '{v, dz, sat}};
		plan.push_back(r);
	endfunction

	// ---------------- result checking ----------------

	always @(posedge clk) begin
		fx_result_t exp_r;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with none expected: value %h dz %b sat %b",
					$time, result_value, divide_by_zero, saturated);
				errors++;
			end else begin
				exp_r = pending_results.pop_front();
				if (result_value !== exp_r.value) begin
					$display("%0t: result_value expected %h actual %h",
						$time, exp_r.value, result_value);
					errors++;
				end
				if (divide_by_zero !== exp_r.dz) begin
					$display("%0t: divide_by_zero expected %b actual %b",
						$time, exp_r.dz, divide_by_zero);
					errors++;
				end
				if (saturated !== exp_r.sat) begin
					$display("%0t: saturated expected %b actual %b",
						$time, exp_r.sat, saturated);
					errors++;
				end
			end
		end
	end

	// ---------------- main sequence ----------------

	initial begin
		fx_result_t none;
		req_t       rq;
		int         sent;
		none          = '{0, 0, 0};
		errors        = 0;
		cycles        = 0;
		quiet         = 1'b0;
		arst_n        = 1'b0;
		start         = 1'b0;
		req_type      = REQ_WR_NUM;
		coeff_index   = '0;
		operand_value = '0;
		cfg_valid     = 1'b0;
		cfg_index     = CFG_NUM_TERMS;
		cfg_data      = '0;
		num_cnt       = '0;
		den_cnt       = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// After reset both counts are zero: p is one and there is no division.
		add_item(REQ_EVAL,  0, 0,       1, ONE_FX, 0, 0);
		add_item(REQ_DERIV, 0, S32_MAX, 1, 0,      0, 0);
		for (int i = 0; i < MAX_TERMS; i++) begin
			plan.push_back('{ROW_ITEM, 0, 0, REQ_WR_NUM, i[3:0], pick_operand(), 0, none});
			plan.push_back('{ROW_ITEM, 0, 0, REQ_WR_DEN, i[3:0], pick_operand(), 0, none});
		end
		// extreme coefficients in both end slots
		add_item(REQ_WR_NUM, 0,  S32_MAX, 0, 0, 0, 0);
		add_item(REQ_WR_NUM, 15, S32_MIN, 0, 0, 0, 0);
		add_item(REQ_WR_DEN, 0,  0,       0, 0, 0, 0);
		// one numerator term: the value is the constant itself, the derivative zero
		add_cfg(1, 0);
		add_item(REQ_EVAL,  0, S32_MIN, 1, S32_MAX, 0, 0);
		add_item(REQ_DERIV, 0, S32_MAX, 1, 0,       0, 0);
		// zero constant divisor, for value and derivative
		add_cfg(1, 1);
		add_item(REQ_EVAL,  0, ONE_FX, 1, S32_MAX, 1, 0);
		add_item(REQ_DERIV, 0, ONE_FX, 1, S32_MAX, 1, 0);
		add_item(REQ_WR_DEN, 0, ONE_FX, 0, 0, 0, 0);
		add_item(REQ_WR_NUM, 1, S32_MAX, 0, 0, 0, 0);
		add_cfg(2, 1);
		add_item(REQ_EVAL,  0, S32_MAX, 0, 0, 0, 0);
		add_item(REQ_DERIV, 0, S32_MIN, 0, 0, 0, 0);
		// full tables, then counts beyond the table size (clamped)
		add_cfg(16, 16);
		add_item(REQ_EVAL,  0, S32_MIN, 0, 0, 0, 0);
		add_item(REQ_DERIV, 0, S32_MAX, 0, 0, 0, 0);
		add_cfg(31, 17);
		add_item(REQ_EVAL,  0, ONE_FX, 0, 0, 0, 0);
		add_item(REQ_DERIV, 0, -ONE_FX, 0, 0, 0, 0);
		add_cfg(0, 2);
		add_item(REQ_DERIV, 0, ONE_FX, 0, 0, 0, 0);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG)
				set_terms(plan[i].n_cnt, plan[i].d_cnt);
			else
				send_item(plan[i].req, plan[i].idx, plan[i].operand,
					plan[i].typed, plan[i].want);
		end

		// Random phases: new counts, then a mix of table writes and evaluations.
		// All slots were written above, so any count reads defined entries.
		sent = 0;
		while (sent < RAND_ITEMS) begin
			case ($urandom_range(0, 7))
				0: set_terms(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
				1: set_terms(5'd16, 5'($urandom_range(0, 1)));
				2: set_terms(5'($urandom_range(0, 2)), 5'd0);
				default: set_terms(5'($urandom_range(0, 5)), 5'($urandom_range(0, 5)));
			endcase
			repeat ($urandom_range(20, 60)) begin
				quiet = (sent > 600 && sent < 900);
				rq = req_t'($urandom_range(0, 3));
				send_item(rq, 4'($urandom_range(0, 15)), pick_operand(), 0, none);
				sent++;
			end
		end

		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

### sim.f
design/rfe_pkg.sv
design/rfe_ctrl.sv
design/rfe_datapath.sv
design/rational_function_evaluator_top.sv
tb/rational_function_evaluator_top_test.sv
